FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted priority queue: action codes, word widths and the
// types that pass between the top level and its cells. No dependencies.
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int SPQ_VALUE_W  = 32;
  localparam int SPQ_OCC_W    = 5;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP_MIN = 2'd1,
    ACT_POP_MAX = 2'd2
  } action_t;

  // Operation broadcast to every cell at once.
  typedef struct packed {
    logic                          insert;
    logic                          pop_min;
    logic                          pop_max;
    logic signed [SPQ_VALUE_W-1:0] value;
  } cell_op_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic signed [SPQ_VALUE_W-1:0] value;
    logic                          occupied;
    logic                          goes_after;
  } cell_link_t;

endpackage

FILE: hdl/spq_in_if.sv
`timescale 1ns / 1ps
// Input channel of the sorted priority queue: valid/ready plus one command word.
// Depends on spq_pkg for the field widths.
interface spq_in_if import spq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SPQ_VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

FILE: hdl/spq_out_if.sv
`timescale 1ns / 1ps
// Result channel of the sorted priority queue: valid/ready plus one result word.
// Depends on spq_pkg for the field widths.
interface spq_out_if import spq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SPQ_VALUE_W-1:0] out_value;
  logic                          out_valid;
  logic                          overflow;
  logic                          empty_res;
  logic [SPQ_OCC_W-1:0]          occupancy;

  modport source (output valid, output out_value, output out_valid, output overflow,
                  output empty_res, output occupancy, input ready);
  modport sink   (input valid, input out_value, input out_valid, input overflow,
                  input empty_res, input occupancy, output ready);
endinterface

FILE: hdl/spq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds a value and its occupied flag,
// and shifts left or right with its neighbors. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_op_t                      op_i,
  input  cell_link_t                    left_i,
  input  cell_link_t                    right_i,
  output cell_link_t                    link_o,
  output logic signed [SPQ_VALUE_W-1:0] tail_value_o
);

  logic signed [SPQ_VALUE_W-1:0] value_r, value_nxt;
  logic                          occupied_r, occupied_nxt;
  logic                          goes_after;

  // The new value lands after every stored value that is not larger.
  assign goes_after = occupied_r && (value_r <= op_i.value);

  always_comb begin
    value_nxt    = value_r;
    occupied_nxt = occupied_r;
    if (op_i.insert) begin
      if (!goes_after) begin
        if (left_i.goes_after) begin
          value_nxt    = op_i.value;
          occupied_nxt = 1'b1;
        end else begin
          value_nxt    = left_i.value;
          occupied_nxt = left_i.occupied;
        end
      end
    end else if (op_i.pop_min) begin
      value_nxt    = right_i.value;
      occupied_nxt = right_i.occupied;
    end else if (op_i.pop_max) begin
      occupied_nxt = occupied_r && right_i.occupied;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupied_r <= 1'b0;
    end else begin
      occupied_r <= occupied_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link_o.value      = value_r;
  assign link_o.occupied   = occupied_r;
  assign link_o.goes_after = goes_after;

  // Only the last occupied cell drives the tail bus.
  assign tail_value_o = (occupied_r && !right_i.occupied) ? value_r : '0;

endmodule

FILE: hdl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Sorted double-ended priority queue. It keeps up to CAPACITY signed 32-bit
// values in ascending order in a row of cells, one value per cell, and each
// word on the input channel inserts a value, removes the smallest or removes
// the largest. An insert compares the new value against every cell at once
// and the row opens a gap in one step; equal values keep arrival order. Every
// input word gives exactly one result word, which is held in an output
// register and appears in the cycle after the word is accepted. A new word is
// accepted while the result slot is empty or in the same cycle that the
// waiting result is taken; while a result waits unread, the input stalls. The
// cycle's work is set by one 32-bit signed compare in each cell plus the
// selection of the tail cell for a remove-largest. Removing from an empty
// queue returns out_valid low and a zero value; inserting into a full queue
// drops the value and sets overflow. Occupancy is reported modulo 32. No
// clearing pass is needed after reset; the queue is usable at once.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Occupancy of the row; the occupied flags in the cells always agree.
  logic [CNT_W-1:0] count_r, count_nxt;

  logic accept;
  logic full;
  logic empty;
  cell_op_t op;

  cell_link_t                    links [CAPACITY];
  logic signed [SPQ_VALUE_W-1:0] tails [CAPACITY];
  logic signed [SPQ_VALUE_W-1:0] tail_value;
  logic [CAPACITY-1:0]           occ_vec;

  // Result register.
  logic                          res_pending_r, res_pending_nxt;
  logic signed [SPQ_VALUE_W-1:0] res_value_r, res_value_nxt;
  logic                          res_valid_r, res_valid_nxt;
  logic                          res_over_r, res_over_nxt;
  logic                          res_empty_r, res_empty_nxt;
  logic [SPQ_OCC_W-1:0]          res_occ_r, res_occ_nxt;
  logic [CNT_W+SPQ_OCC_W-1:0]    count_ext;

  // A new word is taken whenever the result slot is free or being emptied.
  assign in_ch.ready = !res_pending_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Decode the word into the operation that the cells carry out. Full and
  // empty queues turn the operation into a no-op for the row.
  always_comb begin
    op.insert  = 1'b0;
    op.pop_min = 1'b0;
    op.pop_max = 1'b0;
    op.value   = in_ch.value;
    if (accept) begin
      case (in_ch.action)
        ACT_INSERT:  op.insert  = !full;
        ACT_POP_MIN: op.pop_min = !empty;
        ACT_POP_MAX: op.pop_max = !empty;
        default: ;
      endcase
    end
  end

  // The row of cells. The head cell sees a neighbor that always lets the
  // new value in; the last cell sees an empty neighbor on its right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;

    if (i == 0) begin : g_head
      assign left_link = '{value: '0, occupied: 1'b1, goes_after: 1'b1};
    end else begin : g_left
      assign left_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_link = '{value: '0, occupied: 1'b0, goes_after: 1'b0};
    end else begin : g_right
      assign right_link = links[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op_i         (op),
      .left_i       (left_link),
      .right_i      (right_link),
      .link_o       (links[i]),
      .tail_value_o (tails[i])
    );

    assign occ_vec[i] = links[i].occupied;
  end

  // At most one cell drives a non-zero tail value, so an OR collects it.
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_value = tail_value | tails[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop_min || op.pop_max) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext = {{SPQ_OCC_W{1'b0}}, count_nxt};

  always_comb begin
    res_pending_nxt = res_pending_r;
    res_value_nxt   = res_value_r;
    res_valid_nxt   = res_valid_r;
    res_over_nxt    = res_over_r;
    res_empty_nxt   = res_empty_r;
    res_occ_nxt     = res_occ_r;
    if (out_ch.ready) begin
      res_pending_nxt = 1'b0;
    end
    if (accept) begin
      res_pending_nxt = 1'b1;
      res_value_nxt   = op.pop_min ? links[0].value :
                        op.pop_max ? tail_value : '0;
      res_valid_nxt   = op.pop_min || op.pop_max;
      res_over_nxt    = (in_ch.action == ACT_INSERT) && full;
      res_empty_nxt   = (count_nxt == '0);
      res_occ_nxt     = count_ext[SPQ_OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      res_pending_r <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      res_pending_r <= res_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    res_valid_r <= res_valid_nxt;
    res_over_r  <= res_over_nxt;
    res_empty_r <= res_empty_nxt;
    res_occ_r   <= res_occ_nxt;
  end

  assign out_ch.valid     = res_pending_r;
  assign out_ch.out_value = res_value_r;
  assign out_ch.out_valid = res_valid_r;
  assign out_ch.overflow  = res_over_r;
  assign out_ch.empty_res = res_empty_r;
  assign out_ch.occupancy = res_occ_r;

`ifndef SYNTH
  // The count never runs past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("queue count exceeds capacity");

  // The occupied flags in the row always add up to the count.
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_vec) == int'(count_r))
    else $error("cell occupied flags disagree with count");

  // An insert into a queue with room grows it by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.action == ACT_INSERT) && !full |=>
      count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue");

  // A result never reports both a removed value and a dropped insert.
  a_valid_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_valid |-> !out_ch.overflow)
    else $error("result flags removed value and overflow together");
`endif

endmodule
